@@ rtl/core/wmma_pkg.sv @@
package wmma_pkg;

  // widths of the stream fields and the window register
  localparam int unsigned SampleFieldW = 32;
  localparam int unsigned ResultFieldW = 32;
  localparam int unsigned WinLenW      = 16;
  localparam logic [WinLenW-1:0] WinLenReset = 16'd100;

  // status of the serial divider as seen by the controller
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

@@ rtl/core/wmma_div.sv @@
module wmma_div import wmma_pkg::*; #(
  parameter int unsigned DividendW = 48,
  parameter int unsigned DivisorW  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output div_status_t          status_o,
  output logic [DividendW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic [DividendW-1:0] dvd_q, dvd_d;
  logic [DivisorW-1:0]  dvs_q;
  logic [DivisorW:0]    rem_q, rem_d;
  logic [DivisorW:0]    rem_sh;
  logic [DivisorW:0]    diff;
  logic                 qbit;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q;
  logic                 done_q;

  // one quotient bit per cycle, restoring form
  always_comb begin
    rem_sh = {rem_q[DivisorW-1:0], dvd_q[DividendW-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    qbit   = (rem_sh >= {1'b0, dvs_q});
    rem_d  = qbit ? diff : rem_sh;
    dvd_d  = {dvd_q[DividendW-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        dvd_q  <= dividend_i;
        dvs_q  <= divisor_i;
        rem_q  <= '0;
        cnt_q  <= CntW'(DividendW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        dvd_q <= dvd_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = dvd_q;

endmodule

@@ rtl/core/windowed_min_max_average_top.sv @@
// Windowed min / max / mean statistics. Each sample transfer on the slave stream is folded
// into a running minimum, maximum, sum and count; when the count reaches window_length (a
// length of zero acts as one, and a count at its ceiling always closes) one result transfer
// carries the window minimum, maximum and truncated mean, and the statistics restart. All
// arithmetic is bit serial: the compares and the sum update walk one bit per cycle through
// rotating registers, and no new sample is taken until the last one is through. A
// window-closing sample then runs the restoring divider, one quotient bit per cycle over
// the sum width, and its result waits in the hold state until the output register is free.
// A finished result sits in the output register, so the next sample is taken while it
// waits.
module windowed_min_max_average_top import wmma_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // window_length register write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [WinLenW-1:0]        cfg_data_i,      // window_length
  // sample stream
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [SampleFieldW-1:0]   s_axis_tdata_i,  // sample
  // result stream
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [3*ResultFieldW-1:0] m_axis_tdata_o   // window_min, window_max, window_avg
);

  localparam int unsigned SumW  = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int unsigned BitW  = $clog2(SumW);
  localparam int unsigned CmpW  = (COUNT_WIDTH > WinLenW) ? COUNT_WIDTH : WinLenW;
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_DIV,
    S_HOLD
  } state_e;

  state_e                   state_q;
  logic [WinLenW-1:0]       win_len_q;
  logic [SAMPLE_WIDTH-1:0]  sample_q;
  logic [SAMPLE_WIDTH-1:0]  min_q, max_q;
  logic [SumW-1:0]          sum_q, sum_d;
  logic [COUNT_WIDTH-1:0]   count_q;
  logic [BitW-1:0]          bit_q;
  logic                     carry_q, carry_d;
  logic                     lt_q, gt_q;
  logic [SAMPLE_WIDTH-1:0]  pend_min_q, pend_max_q;
  logic                     out_valid_q;
  logic [3*ResultFieldW-1:0] out_data_q;

  logic                     in_word;      // bit position still inside the sample
  logic                     last_bit;
  logic                     s_bit;
  logic                     sum_bit;
  logic [SAMPLE_WIDTH-1:0]  min_fin, max_fin;
  logic [COUNT_WIDTH-1:0]   count_inc;
  logic [CmpW-1:0]          win_eff;
  logic                     closes;
  logic                     div_start;
  logic                     out_load;
  div_status_t              div_stat;
  logic [SumW-1:0]          quotient;

  // serial datapath: sample bits lsb first, zeros once past the sample width
  always_comb begin
    in_word  = (bit_q < BitW'(SAMPLE_WIDTH));
    last_bit = (bit_q == BitW'(SumW - 1));
    s_bit    = in_word & sample_q[0];
    sum_bit  = s_bit ^ sum_q[0] ^ carry_q;
    carry_d  = (s_bit & sum_q[0]) | (s_bit & carry_q) | (sum_q[0] & carry_q);
    sum_d    = {sum_bit, sum_q[SumW-1:1]};
    min_fin  = lt_q ? sample_q : min_q;
    max_fin  = gt_q ? sample_q : max_q;
  end

  // window close decision, evaluated on the last serial bit
  always_comb begin
    count_inc = (count_q == CountMax) ? count_q : count_q + COUNT_WIDTH'(1);
    win_eff   = (win_len_q == '0) ? CmpW'(1) : CmpW'(win_len_q);
    closes    = (CmpW'(count_inc) >= win_eff) || (count_inc == CountMax);
    div_start = (state_q == S_ACC) && last_bit && closes;
    out_load  = (state_q == S_HOLD) && (!out_valid_q || m_axis_tready_i);
  end

  wmma_div #(
    .DividendW (SumW),
    .DivisorW  (COUNT_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (count_inc),
    .status_o   (div_stat),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_len_q   <= WinLenReset;
      sample_q    <= '0;
      min_q       <= '1;
      max_q       <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      bit_q       <= '0;
      carry_q     <= 1'b0;
      lt_q        <= 1'b0;
      gt_q        <= 1'b0;
      pend_min_q  <= '0;
      pend_max_q  <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        win_len_q <= cfg_data_i;
      end

      // result register: drained by the sink, refilled from the hold state
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {ResultFieldW'(quotient[SAMPLE_WIDTH-1:0]),
                        ResultFieldW'(pend_max_q),
                        ResultFieldW'(pend_min_q)};
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            sample_q <= s_axis_tdata_i[SAMPLE_WIDTH-1:0];
            bit_q    <= '0;
            carry_q  <= 1'b0;
            lt_q     <= 1'b0;
            gt_q     <= 1'b0;
            state_q  <= S_ACC;
          end
        end
        S_ACC: begin
          carry_q <= carry_d;
          bit_q   <= bit_q + BitW'(1);
          if (!last_bit) begin
            sum_q <= sum_d;
          end
          if (in_word) begin
            // lsb-first compare: the highest differing bit decides
            if (sample_q[0] != min_q[0]) begin
              lt_q <= min_q[0];
            end
            if (sample_q[0] != max_q[0]) begin
              gt_q <= sample_q[0];
            end
            sample_q <= {sample_q[0], sample_q[SAMPLE_WIDTH-1:1]};
            min_q    <= {min_q[0], min_q[SAMPLE_WIDTH-1:1]};
            max_q    <= {max_q[0], max_q[SAMPLE_WIDTH-1:1]};
          end
          if (last_bit) begin
            if (closes) begin
              pend_min_q <= min_fin;
              pend_max_q <= max_fin;
              min_q      <= '1;
              max_q      <= '0;
              sum_q      <= '0;
              count_q    <= '0;
              state_q    <= S_DIV;
            end else begin
              min_q   <= min_fin;
              max_q   <= max_fin;
              sum_q   <= sum_d;
              count_q <= count_inc;
              state_q <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_q <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // no sample is taken while the divider works on a closed window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> !s_axis_tready_o)
    else $error("sample accepted during division");

  // a division is never restarted before it finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // a new result only ever comes out of the hold state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_HOLD))
    else $error("result raised outside hold state");

  // the divider completion is only seen while waiting for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == S_DIV)
    else $error("division finished outside divide state");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import wmma_pkg::*;

  localparam int unsigned HalfPeriod   = 6;
  localparam int unsigned SettleCycles = 130;   // one sample plus the divider, with margin
  localparam int unsigned HoldCycles   = 600;   // long enough to fill the output register
  localparam int unsigned QuietLimit   = 3000;  // cycles with no transfer at all
  localparam int unsigned RandomItems  = 530;

  // one result transfer, window_min in the lowest bits
  typedef struct packed {
    logic [ResultFieldW-1:0] avg;
    logic [ResultFieldW-1:0] max;
    logic [ResultFieldW-1:0] min;
  } window_stats_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;

  // directed stimulus: a register write, or a sample repeated reps times
  typedef struct packed {
    row_kind_e               kind;
    logic [SampleFieldW-1:0] value;
    logic [7:0]              reps;
    logic                    has_lit;
    logic [ResultFieldW-1:0] lit_min;
    logic [ResultFieldW-1:0] lit_max;
    logic [ResultFieldW-1:0] lit_avg;
  } stim_row_t;

  localparam int unsigned NumRows = 23;

  // expected results typed in only where they are obvious
  stim_row_t directed_plan [NumRows] = '{
    // reset window length of 100, constant samples
    '{ROW_SAMPLE, 32'd7, 8'd100, 1'b1, 32'd7, 32'd7, 32'd7},
    '{ROW_CFG, 32'd1, 8'd1, 1'b0, 32'd0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd0, 8'd1, 1'b1, 32'd0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 8'd1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    // zero length acts as one
    '{ROW_CFG, 32'd0, 8'd1, 1'b0, 32'd0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'hA5A5_A5A5, 8'd1, 1'b1, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 32'hA5A5_A5A5},
    '{ROW_SAMPLE, 32'h5A5A_5A5A, 8'd1, 1'b1, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 32'h5A5A_5A5A},
    '{ROW_CFG, 32'd2, 8'd1, 1'b0, 32'd0, 32'd0, 32'd0},
    // sum carries beyond the sample width
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 8'd2, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{ROW_SAMPLE, 32'd0, 8'd1, 1'b0, 32'd0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 8'd1, 1'b1, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF},
    // mean truncates
    '{ROW_SAMPLE, 32'd3, 8'd1, 1'b0, 32'd0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd4, 8'd1, 1'b1, 32'd3, 32'd4, 32'd3},
    // longest window, then lowered below the count mid-window
    '{ROW_CFG, 32'd65535, 8'd1, 1'b0, 32'd0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd10, 8'd1, 1'b0, 32'd0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd20, 8'd1, 1'b0, 32'd0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd30, 8'd1, 1'b0, 32'd0, 32'd0, 32'd0},
    '{ROW_CFG, 32'd2, 8'd1, 1'b0, 32'd0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd40, 8'd1, 1'b1, 32'd10, 32'd40, 32'd25},
    '{ROW_CFG, 32'd3, 8'd1, 1'b0, 32'd0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd9, 8'd1, 1'b0, 32'd0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd1, 8'd1, 1'b0, 32'd0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd5, 8'd1, 1'b1, 32'd1, 32'd9, 32'd5}
  };

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid;
  logic                      cfg_ready_o;
  logic [WinLenW-1:0]        cfg_data;
  logic                      s_tvalid;
  logic                      s_axis_tready_o;
  logic [SampleFieldW-1:0]   s_tdata;        // sample
  logic                      m_axis_tvalid_o;
  logic                      m_tready;
  logic [3*ResultFieldW-1:0] m_axis_tdata_o; // window_min, window_max, window_avg

  // control between the stimulus and the receiver
  logic steady;      // no idling on either side
  logic hold_armed;  // receiver starts its long hold-off
  logic hold_done;

  // model of the statistics block
  logic [WinLenW-1:0]               win_len_model;
  logic [SampleFieldW-1:0]          run_min;
  logic [SampleFieldW-1:0]          run_max;
  logic [SampleFieldW+WinLenW-1:0]  run_sum;
  logic [WinLenW-1:0]               run_count;

  window_stats_t pending_windows [$];
  int unsigned   mismatches;
  int unsigned   samples_sent;
  int unsigned   quiet_cycles;

  windowed_min_max_average_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic void clear_window();
    run_min   = '1;
    run_max   = '0;
    run_sum   = '0;
    run_count = '0;
  endfunction

  // fold one sample into the window; returns the stats when the window closes
  function automatic logic fold_sample(input logic [SampleFieldW-1:0] v,
                                       output window_stats_t stats);
    logic [WinLenW-1:0] eff_len;
    logic               closes;
    eff_len = (win_len_model == '0) ? WinLenW'(1) : win_len_model;
    if (v < run_min) run_min = v;
    if (v > run_max) run_max = v;
    run_sum = run_sum + {{WinLenW{1'b0}}, v};
    // count saturates, and a full count always closes the window
    if (run_count != '1) run_count = run_count + 1'b1;
    closes = (run_count >= eff_len) || (run_count == '1);
    stats  = '0;
    if (closes) begin
      stats.min = run_min;
      stats.max = run_max;
      stats.avg = ResultFieldW'(run_sum / run_count);
      clear_window();
    end
    return closes;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    mismatches++;
  endtask

  // every expected result in, then let a sample still in flight finish
  task automatic drain_and_settle();
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_window_len(input logic [WinLenW-1:0] len);
    s_tvalid <= 1'b0;
    drain_and_settle();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid     <= 1'b0;
    win_len_model = len;
  endtask

  // offer one sample; tvalid stays high after the transfer
  task automatic push_sample(input logic [SampleFieldW-1:0] v, input logic use_lit,
                             input window_stats_t lit);
    window_stats_t predicted;
    while (!steady && $urandom_range(99) < 18) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    samples_sent++;
    if (fold_sample(v, predicted)) pending_windows.push_back(use_lit ? lit : predicted);
  endtask

  function automatic logic [SampleFieldW-1:0] draw_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return '1;
    if (pick < 35) return SampleFieldW'($urandom_range(255));
    if (pick < 45) return ~SampleFieldW'($urandom_range(255));
    return $urandom;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    window_stats_t got;
    window_stats_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got = window_stats_t'(m_axis_tdata_o);
      if (pending_windows.size() == 0) begin
        report_mismatch("unexpected result transfer (window_min)", got.min, '0);
      end else begin
        want = pending_windows.pop_front();
        if (got.min !== want.min) report_mismatch("window_min", got.min, want.min);
        if (got.max !== want.max) report_mismatch("window_max", got.max, want.max);
        if (got.avg !== want.avg) report_mismatch("window_avg", got.avg, want.avg);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)
        || (cfg_valid && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // result receiver: random stalls, one long hold-off
  initial begin
    m_tready  = 1'b0;
    hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_tready <= steady || ($urandom_range(99) >= 18);
    end
  end

  // stimulus
  initial begin
    window_stats_t      lit;
    logic [WinLenW-1:0] len;
    int unsigned        count;
    int unsigned        pick;
    int unsigned        phase;

    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    steady       = 1'b0;
    hold_armed   = 1'b0;
    mismatches   = 0;
    samples_sent = 0;
    quiet_cycles = 0;
    win_len_model = WinLenReset;
    clear_window();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    for (int r = 0; r < NumRows; r++) begin
      if (directed_plan[r].kind == ROW_CFG) begin
        write_window_len(directed_plan[r].value[WinLenW-1:0]);
      end else begin
        lit.min = directed_plan[r].lit_min;
        lit.max = directed_plan[r].lit_max;
        lit.avg = directed_plan[r].lit_avg;
        for (int k = 0; k < directed_plan[r].reps; k++) begin
          push_sample(directed_plan[r].value, directed_plan[r].has_lit, lit);
        end
      end
    end

    // random part: phases of one window length each, mostly short windows
    samples_sent = 0;
    phase        = 0;
    while (samples_sent < RandomItems) begin
      pick  = $urandom_range(99);
      count = $urandom_range(40, 4);
      if (pick < 8) begin
        len = '0;
      end else if (pick < 14) begin
        // longest window, left open so a later phase lowers it mid-window
        len   = '1;
        count = $urandom_range(10, 3);
      end else if (pick < 20) begin
        len = WinLenW'(100);
      end else if (pick < 30) begin
        len = WinLenW'($urandom_range(40, 9));
      end else begin
        len = WinLenW'($urandom_range(8, 1));
      end
      // one phase with single-sample windows while the receiver holds off
      if (phase == 2) begin
        len   = WinLenW'(1);
        count = 24;
      end
      write_window_len(len);
      steady <= (phase >= 5 && phase <= 8);
      if (phase == 2) hold_armed <= 1'b1;
      repeat (count) push_sample(draw_sample(), 1'b0, '0);
      phase++;
    end

    s_tvalid <= 1'b0;
    drain_and_settle();
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
